/* hw/rtl/assert_macros.svh */
// assertion macros shared by the ring generator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/crvg_pkg.sv */
// types, constants and the sine/cosine tables of the ring vertex generator
package crvg_pkg;

  localparam int SEGMENTS = 16;
  localparam int MAX_OUT = 16;
  localparam int SEG_EFF = (SEGMENTS < 1) ? 1 : SEGMENTS;
  localparam int SEG_HALF = SEG_EFF / 2;
  localparam int COUNT = (SEG_EFF > MAX_OUT) ? MAX_OUT : SEG_EFF;
  localparam int IDX_W = $clog2(MAX_OUT);

  typedef logic [63:0] u64_t;
  typedef logic signed [63:0] s64_t;

  localparam u64_t ONE_Q30 = 64'd1 << 30;
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [31:0] VERT_LIMIT = 32'sd1063004405;

  typedef struct packed {
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic [30:0]        ring_radius;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
    logic               degenerate;
  } out_item_t;

  // three q30 / q16.16 components, element 0 is x
  typedef logic [2:0][31:0] vec3_t;
  typedef logic [2:0][63:0] wide3_t;

  // context that rides along the normalizer pipelines
  typedef struct packed {
    vec3_t       centre;
    logic [30:0] radius;
    logic        degen;
    vec3_t       n;
    vec3_t       u;
  } ctx_t;

  typedef struct packed {
    vec3_t       centre;
    logic [30:0] radius;
    logic        degen;
    vec3_t       u;
    vec3_t       v;
  } ring_item_t;

  typedef logic [MAX_OUT-1:0][31:0] tab_t;

  // truncating unsigned quotient by shift and subtract, table building only
  function automatic u64_t div_u64(input u64_t num, input u64_t den);
    u64_t quo;
    u64_t rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // taylor series sine on [0, pi/2], q30, evaluated at elaboration
  function automatic u64_t sin_q30(input u64_t x);
    u64_t x2;
    u64_t t;
    u64_t n;
    s64_t sum;
    x2 = (x * x) >> 30;
    t = x;
    sum = s64_t'(x);
    for (n = 2; n <= 16; n += 2) begin
      t = div_u64((t * x2) >> 30, n * (n + 64'd1));
      if (n[1]) sum = sum - s64_t'(t);
      else sum = sum + s64_t'(t);
    end
    if (sum < 0) sum = 0;
    if (sum > s64_t'(ONE_Q30)) sum = s64_t'(ONE_Q30);
    return u64_t'(sum);
  endfunction

  function automatic tab_t build_tab(input logic want_cos);
    tab_t tab;
    u64_t p;
    u64_t f;
    u64_t x;
    u64_t q;
    s64_t s0;
    s64_t c0;
    s64_t sn;
    s64_t cs;
    for (int k = 0; k < MAX_OUT; k++) begin
      p = div_u64((u64_t'(k) << 32) + u64_t'(SEG_HALF), u64_t'(SEG_EFF));
      q = (p >> 30) & 64'd3;
      f = p & 64'h3FFF_FFFF;
      x = (f * HALF_PI_Q30) >> 30;
      if (f == 0) begin
        s0 = 0;
        c0 = s64_t'(ONE_Q30);
      end else begin
        s0 = s64_t'(sin_q30(x));
        c0 = s64_t'(sin_q30(HALF_PI_Q30 - x));
      end
      unique case (q)
        64'd0: begin sn = s0;  cs = c0;  end
        64'd1: begin sn = c0;  cs = -s0; end
        64'd2: begin sn = -s0; cs = -c0; end
        default: begin sn = -c0; cs = s0; end
      endcase
      tab[k] = want_cos ? cs[31:0] : sn[31:0];
    end
    return tab;
  endfunction

  localparam tab_t SIN_TAB = build_tab(1'b0);
  localparam tab_t COS_TAB = build_tab(1'b1);

endpackage

/* hw/rtl/crvg_unit3.sv */
// pipelined normalizer: scales a 3-vector to a q30 unit vector
`include "assert_macros.svh"

module crvg_unit3 (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  crvg_pkg::ctx_t   in_ctx,
  input  crvg_pkg::wide3_t in_w,
  output logic            out_valid,
  output crvg_pkg::ctx_t   out_ctx,
  output crvg_pkg::vec3_t  out_v,
  output logic            out_nz
);
  import crvg_pkg::*;

  localparam int SQ_STEPS = 32;
  localparam int DIV_STEPS = 31;

  typedef struct packed {
    ctx_t       ctx;
    logic [2:0] neg;
    logic       nz;
  } hd_t;

  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [5:0] b;
    b = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) b = 6'(i);
    end
    return b;
  endfunction

  // magnitudes
  logic       a_valid;
  hd_t        a_hd;
  wide3_t     a_m;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_hd.ctx <= in_ctx;
      a_hd.nz <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        a_hd.neg[i] <= in_w[i][63];
        a_m[i] <= in_w[i][63] ? (64'd0 - in_w[i]) : in_w[i];
      end
    end
  end

  // largest magnitude
  logic        b_valid;
  hd_t         b_hd;
  wide3_t      b_m;
  logic [63:0] b_mx;
  logic [63:0] mx01;
  assign mx01 = (a_m[0] > a_m[1]) ? a_m[0] : a_m[1];
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_hd <= a_hd;
      b_m <= a_m;
      b_mx <= (mx01 > a_m[2]) ? mx01 : a_m[2];
    end
  end

  // leading one gives the scaling shifts
  logic        c_valid;
  hd_t         c_hd;
  hd_t         c_hd_next;
  wide3_t      c_m;
  logic [63:0] c_mx;
  logic [5:0]  c_rs;
  logic [4:0]  c_ls;
  logic [5:0]  lead;
  assign lead = msb64(b_mx);
  always_comb begin
    c_hd_next = b_hd;
    c_hd_next.nz = (b_mx != '0);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_hd <= c_hd_next;
      c_m <= b_m;
      c_mx <= b_mx;
      c_rs <= (lead >= 6'd31) ? (lead - 6'd31) : 6'd0;
      c_ls <= (lead < 6'd30) ? 5'(6'd30 - lead) : 5'd0;
    end
  end

  // shift so the largest lands in [2^30, 2^32)
  logic        d_valid;
  hd_t         d_hd;
  vec3_t       d_m;
  logic [31:0] d_mx;
  wide3_t      d_sh;
  logic [63:0] d_mx_sh;
  always_comb begin
    for (int i = 0; i < 3; i++) d_sh[i] = (c_m[i] >> c_rs) << c_ls;
    d_mx_sh = (c_mx >> c_rs) << c_ls;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
    if (en) begin
      d_hd <= c_hd;
      for (int i = 0; i < 3; i++) d_m[i] <= d_sh[i][31:0];
      d_mx <= d_mx_sh[31:0];
    end
  end

  // one more halving when above 2^31
  logic  e_valid;
  hd_t   e_hd;
  vec3_t e_m;
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
    if (en) begin
      e_hd <= d_hd;
      for (int i = 0; i < 3; i++) begin
        e_m[i] <= (d_mx > 32'h8000_0000) ? (d_m[i] >> 1) : d_m[i];
      end
    end
  end

  // squares
  logic   f_valid;
  hd_t    f_hd;
  vec3_t  f_m;
  wide3_t f_sq;
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
    if (en) begin
      f_hd <= e_hd;
      f_m <= e_m;
      for (int i = 0; i < 3; i++) f_sq[i] <= 64'(e_m[i]) * 64'(e_m[i]);
    end
  end

  // square root, one result bit per stage
  logic        sq_valid [SQ_STEPS+1];
  hd_t         sq_hd    [SQ_STEPS+1];
  vec3_t       sq_m     [SQ_STEPS+1];
  logic [63:0] sq_s     [SQ_STEPS+1];
  logic [63:0] sq_r     [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= f_valid;
    end
    if (en) begin
      sq_hd[0] <= f_hd;
      sq_m[0] <= f_m;
      sq_s[0] <= f_sq[0] + f_sq[1] + f_sq[2];
      sq_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [64:0] trial;
    logic        ge;
    assign trial = {1'b0, sq_r[j]} + {1'b0, BIT};
    assign ge = ({1'b0, sq_s[j]} >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[j+1] <= 1'b0;
      end else if (en) begin
        sq_valid[j+1] <= sq_valid[j];
      end
      if (en) begin
        sq_hd[j+1] <= sq_hd[j];
        sq_m[j+1] <= sq_m[j];
        sq_s[j+1] <= ge ? (sq_s[j] - trial[63:0]) : sq_s[j];
        sq_r[j+1] <= ge ? ((sq_r[j] >> 1) + BIT) : (sq_r[j] >> 1);
      end
    end
  end

  // rounded division of each component by the length
  logic                   dv_valid [DIV_STEPS+1];
  hd_t                    dv_hd    [DIV_STEPS+1];
  logic [31:0]            dv_len   [DIV_STEPS+1];
  logic [2:0][61:0]       dv_rem   [DIV_STEPS+1];
  logic [2:0][DIV_STEPS-1:0] dv_q  [DIV_STEPS+1];
  logic [31:0]            len;
  assign len = sq_r[SQ_STEPS][31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= sq_valid[SQ_STEPS];
    end
    if (en) begin
      dv_hd[0] <= sq_hd[SQ_STEPS];
      dv_len[0] <= len;
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= {sq_m[SQ_STEPS][i], 30'd0} + {31'd0, len[31:1]};
        dv_q[0][i] <= '0;
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    logic [61:0] dsr;
    logic [2:0]  ge;
    assign dsr = {30'd0, dv_len[j]} << SH;
    always_comb begin
      for (int i = 0; i < 3; i++) ge[i] = (dv_rem[j][i] >= dsr);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (en) begin
        dv_valid[j+1] <= dv_valid[j];
      end
      if (en) begin
        dv_hd[j+1] <= dv_hd[j];
        dv_len[j+1] <= dv_len[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= ge[i] ? (dv_rem[j][i] - dsr) : dv_rem[j][i];
          dv_q[j+1][i] <= dv_q[j][i] | (DIV_STEPS'(ge[i]) << SH);
        end
      end
    end
  end

  // restore signs
  hd_t tail;
  assign tail = dv_hd[DIV_STEPS];
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[DIV_STEPS];
    end
    if (en) begin
      out_ctx <= tail.ctx;
      out_nz <= tail.nz;
      for (int i = 0; i < 3; i++) begin
        if (!tail.nz) out_v[i] <= '0;
        else if (tail.neg[i]) out_v[i] <= 32'd0 - {1'b0, dv_q[DIV_STEPS][i]};
        else out_v[i] <= {1'b0, dv_q[DIV_STEPS][i]};
      end
    end
  end

  `ASSERT_IMPL(a_zero_vec, out_valid && !out_nz, out_v == '0, "zero input must give zero vector")
  `ASSERT_IMPL(a_unit_x, out_valid && out_nz, ($signed(out_v[0]) <= 32'sd1073741824) && ($signed(out_v[0]) >= -32'sd1073741824), "unit component out of range")
  `ASSERT_IMPL(a_unit_z, out_valid && out_nz, ($signed(out_v[2]) <= 32'sd1073741824) && ($signed(out_v[2]) >= -32'sd1073741824), "unit component out of range")

endmodule

/* hw/rtl/crvg_ring.sv */
// point sequencer: walks the angle table and forms centre + rc*u + rs*v
`include "assert_macros.svh"

module crvg_ring (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  crvg_pkg::ring_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crvg_pkg::out_item_t  out_item
);
  import crvg_pkg::*;

  // product in q30 with the magnitude rounded half away from zero
  function automatic logic [31:0] mulq30(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [31:0] r;
    ma = a[31] ? (32'd0 - a) : a;
    mb = b[31] ? (32'd0 - b) : b;
    p = (64'(ma) * 64'(mb)) + (64'd1 << 29);
    r = p[61:30];
    return (a[31] != b[31]) ? (32'd0 - r) : r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] s);
    if (s > 34'sd2147483647) return 32'h7FFF_FFFF;
    if (s < -34'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic logic signed [33:0] sx34(input logic [31:0] v);
    return $signed({{2{v[31]}}, v});
  endfunction

  logic             en;
  logic             issue;
  logic             last_k;
  logic             hold_valid;
  ring_item_t       hold;
  logic [IDX_W-1:0] k;

  assign en = !out_valid || out_ready;
  assign issue = hold_valid && en;
  assign last_k = hold.degen || (k == IDX_W'(COUNT - 1));
  assign in_ready = !hold_valid || (issue && last_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      k <= '0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
      k <= '0;
    end else if (issue) begin
      if (last_k) begin
        hold_valid <= 1'b0;
        k <= '0;
      end else begin
        k <= k + 1'b1;
      end
    end
    if (in_valid && in_ready) hold <= in_item;
  end

  // radius times cos and sin
  logic             p1_valid;
  logic [31:0]      p1_rc;
  logic [31:0]      p1_rs;
  logic [IDX_W-1:0] p1_k;
  logic             p1_last;
  logic             p1_degen;
  vec3_t            p1_centre;
  vec3_t            p1_u;
  vec3_t            p1_v;
  logic [31:0]      radius_q;
  assign radius_q = {1'b0, hold.radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= issue;
    end
    if (en) begin
      p1_rc <= mulq30(radius_q, COS_TAB[k]);
      p1_rs <= mulq30(radius_q, SIN_TAB[k]);
      p1_k <= k;
      p1_last <= last_k;
      p1_degen <= hold.degen;
      p1_centre <= hold.centre;
      p1_u <= hold.u;
      p1_v <= hold.v;
    end
  end

  // offsets along u and v
  logic             p2_valid;
  vec3_t            p2_a;
  vec3_t            p2_b;
  logic [IDX_W-1:0] p2_k;
  logic             p2_last;
  logic             p2_degen;
  vec3_t            p2_centre;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_a[i] <= mulq30(p1_rc, p1_u[i]);
        p2_b[i] <= mulq30(p1_rs, p1_v[i]);
      end
      p2_k <= p1_k;
      p2_last <= p1_last;
      p2_degen <= p1_degen;
      p2_centre <= p1_centre;
    end
  end

  // sum, saturate, output register
  vec3_t pt;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = p2_degen ? 32'd0 : sat32(sx34(p2_centre[i]) + sx34(p2_a[i]) + sx34(p2_b[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p2_valid;
    end
    if (en) begin
      out_item.point_index <= 4'(p2_k);
      out_item.point_x <= pt[0];
      out_item.point_y <= pt[1];
      out_item.point_z <= pt[2];
      out_item.last_point <= p2_last;
      out_item.degenerate <= p2_degen;
    end
  end

  `ASSERT_IMPL(a_degen_single, out_valid && out_item.degenerate, out_item.last_point && (out_item.point_index == '0) && (out_item.point_x == '0), "degenerate result must be a lone zero point")
  `ASSERT_IMPL(a_last_index, out_valid && out_item.last_point && !out_item.degenerate, out_item.point_index == 4'(COUNT - 1), "last point at wrong index")
  `ASSERT_IMPL(a_take_on_last, in_valid && in_ready && hold_valid, issue && last_k, "new transaction taken while ring busy")

endmodule

/* hw/rtl/cylinder_ring_vertex_generator.sv */
// top level: three normalizer pipelines, helper and cross stages, point sequencer
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  item     | item_valid, item_ready, item     | in
//  point    | point_valid, point_ready, point  | out
//
// an item enters the front pipeline in any cycle the pipeline moves. the point
// sequencer emits one point per cycle unless the point output stalls, sixteen per
// item, and takes the next item as it issues the last point; a zero axis gives a
// single point. reset clears all valid bits and the sequencer. a stalled point holds
// the sequencer and its stages; the front pipeline keeps moving until a finished
// basis waits on the busy sequencer.

module cylinder_ring_vertex_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  crvg_pkg::in_item_t  item,
  output logic                point_valid,
  input  logic                point_ready,
  output crvg_pkg::out_item_t point
);
  import crvg_pkg::*;

  function automatic logic [63:0] sx64(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  logic       front_en;
  logic       ring_ready;
  ring_item_t ring_in;

  // axis normalization
  ctx_t   u1_in_ctx;
  wide3_t u1_in_w;
  logic   u1_valid;
  ctx_t   u1_ctx;
  vec3_t  u1_v;
  logic   u1_nz;

  always_comb begin
    u1_in_ctx = '0;
    u1_in_ctx.centre = {item.centre_z, item.centre_y, item.centre_x};
    u1_in_ctx.radius = item.ring_radius;
    u1_in_w = {sx64(item.axis_z), sx64(item.axis_y), sx64(item.axis_x)};
  end

  crvg_unit3 u_norm_n (
    .clk(clk), .rst(rst), .en(front_en),
    .in_valid(item_valid), .in_ctx(u1_in_ctx), .in_w(u1_in_w),
    .out_valid(u1_valid), .out_ctx(u1_ctx), .out_v(u1_v), .out_nz(u1_nz)
  );

  // helper cross product, helper is z unless the axis is near vertical
  logic   h_valid;
  ctx_t   h_ctx;
  ctx_t   h_ctx_next;
  wide3_t h_w;
  logic   vertical;
  assign vertical = ($signed(u1_v[2]) > VERT_LIMIT) || ($signed(u1_v[2]) < -VERT_LIMIT);

  always_comb begin
    h_ctx_next = u1_ctx;
    h_ctx_next.degen = !u1_nz;
    h_ctx_next.n = u1_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (front_en) begin
      h_valid <= u1_valid;
    end
    if (front_en) begin
      h_ctx <= h_ctx_next;
      if (vertical) begin
        h_w[0] <= 64'd0 - sx64(u1_v[2]);
        h_w[1] <= '0;
        h_w[2] <= sx64(u1_v[0]);
      end else begin
        h_w[0] <= sx64(u1_v[1]);
        h_w[1] <= 64'd0 - sx64(u1_v[0]);
        h_w[2] <= '0;
      end
    end
  end

  logic  u2_valid;
  ctx_t  u2_ctx;
  vec3_t u2_v;
  logic  u2_nz;

  crvg_unit3 u_norm_u (
    .clk(clk), .rst(rst), .en(front_en),
    .in_valid(h_valid), .in_ctx(h_ctx), .in_w(h_w),
    .out_valid(u2_valid), .out_ctx(u2_ctx), .out_v(u2_v), .out_nz(u2_nz)
  );

  // n cross u: products, then differences
  logic               x1_valid;
  ctx_t               x1_ctx;
  ctx_t               x1_ctx_next;
  logic signed [63:0] x1_p [6];
  vec3_t              nv;
  assign nv = u2_ctx.n;

  always_comb begin
    x1_ctx_next = u2_ctx;
    x1_ctx_next.u = u2_nz ? u2_v : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_valid <= 1'b0;
    end else if (front_en) begin
      x1_valid <= u2_valid;
    end
    if (front_en) begin
      x1_ctx <= x1_ctx_next;
      x1_p[0] <= $signed(nv[1]) * $signed(u2_v[2]);
      x1_p[1] <= $signed(nv[2]) * $signed(u2_v[1]);
      x1_p[2] <= $signed(nv[2]) * $signed(u2_v[0]);
      x1_p[3] <= $signed(nv[0]) * $signed(u2_v[2]);
      x1_p[4] <= $signed(nv[0]) * $signed(u2_v[1]);
      x1_p[5] <= $signed(nv[1]) * $signed(u2_v[0]);
    end
  end

  logic   x2_valid;
  ctx_t   x2_ctx;
  wide3_t x2_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      x2_valid <= 1'b0;
    end else if (front_en) begin
      x2_valid <= x1_valid;
    end
    if (front_en) begin
      x2_ctx <= x1_ctx;
      x2_w[0] <= x1_p[0] - x1_p[1];
      x2_w[1] <= x1_p[2] - x1_p[3];
      x2_w[2] <= x1_p[4] - x1_p[5];
    end
  end

  logic  u3_valid;
  ctx_t  u3_ctx;
  vec3_t u3_v;
  logic  u3_nz;

  crvg_unit3 u_norm_v (
    .clk(clk), .rst(rst), .en(front_en),
    .in_valid(x2_valid), .in_ctx(x2_ctx), .in_w(x2_w),
    .out_valid(u3_valid), .out_ctx(u3_ctx), .out_v(u3_v), .out_nz(u3_nz)
  );

  // front pipeline moves unless a finished basis waits on a busy sequencer
  assign front_en = !u3_valid || ring_ready;
  assign item_ready = front_en;

  always_comb begin
    ring_in.centre = u3_ctx.centre;
    ring_in.radius = u3_ctx.radius;
    ring_in.degen = u3_ctx.degen;
    ring_in.u = u3_ctx.u;
    ring_in.v = u3_nz ? u3_v : '0;
  end

  crvg_ring u_ring (
    .clk(clk), .rst(rst),
    .in_valid(u3_valid), .in_ready(ring_ready), .in_item(ring_in),
    .out_valid(point_valid), .out_ready(point_ready), .out_item(point)
  );

endmodule
